FILE: rtl/pck_pkg.sv
// Shared types, field widths and default sizes of the planar colour-key compositor.
package pck_pkg;

  localparam int REQ_W     = 2;
  localparam int PLANE_W   = 3;
  localparam int SLOT_W    = 2;
  localparam int ADDR_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 5;
  localparam int LINE_W    = 8;
  localparam int POS_W     = 9;
  localparam int PIX_IDX_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 2;

  localparam int NUM_PLANES  = 8;
  localparam int PLANE_DEPTH = 6144;
  localparam int PLANE_AW    = 13;
  localparam int PAPER_LINES = 192;

  localparam int DEF_NUM_BACKGROUNDS = 4;
  localparam int DEF_IMG_W           = 320;
  localparam int DEF_IMG_H           = 200;
  localparam int DEF_PAPER_X0        = 48;
  localparam int DEF_PAPER_Y0        = 48;

  typedef enum logic [REQ_W-1:0] {
    REQ_PLANE_WR = 2'd0,
    REQ_BG_WR    = 2'd1,
    REQ_RENDER   = 2'd2,
    REQ_NOP      = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BG_ENABLE = 1'd0,
    CFG_BG_SELECT = 1'd1
  } cfg_reg_e;

  // One operation as it travels down the pipeline; a render item becomes
  // eight of these, one per pixel.
  typedef struct packed {
    req_type_e              kind;
    logic [PLANE_W-1:0]     plane;
    logic [SLOT_W-1:0]      bg_slot;
    logic [ADDR_W-1:0]      mem_addr;
    logic [BYTE_W-1:0]      wr_data;
    logic [COL_W-1:0]       column;
    logic [LINE_W-1:0]      line;
    logic [PIX_IDX_W-1:0]   idx;
  } op_t;

  // Swap address bits 5-7 with bits 8-10.
  function automatic logic [PLANE_AW-1:0] swap_addr(input logic [PLANE_AW-1:0] a);
    swap_addr = {a[12:11], a[7:5], a[10:8], a[4:0]};
  endfunction

endpackage

FILE: rtl/pck_in_if.sv
// Request channel: valid/ready handshake with the write and render fields.
interface pck_in_if;
  import pck_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [PLANE_W-1:0]   plane;
  logic [SLOT_W-1:0]    bg_slot;
  logic [ADDR_W-1:0]    mem_addr;
  logic [BYTE_W-1:0]    wr_data;
  logic [COL_W-1:0]     column;
  logic [LINE_W-1:0]    line;

  modport source (output valid, req_type, plane, bg_slot, mem_addr, wr_data, column, line,
                  input ready);
  modport sink   (input valid, req_type, plane, bg_slot, mem_addr, wr_data, column, line,
                  output ready);
endinterface

FILE: rtl/pck_out_if.sv
// Pixel channel: valid/ready handshake with field position and palette index.
interface pck_out_if;
  import pck_pkg::*;

  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   pixel_x;
  logic [POS_W-1:0]   pixel_y;
  logic [BYTE_W-1:0]  pixel_color;
  logic               last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

FILE: rtl/pck_ram.sv
// Generic simple dual-port RAM with registered read.
module pck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pck_expand.sv
// Front stage: take request items and issue one operation per write item or per pixel of a render.
module pck_expand (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  pck_in_if.sink        req,
  output logic          op_valid,
  output pck_pkg::op_t  op
);
  import pck_pkg::*;

  op_t  cur;
  logic cur_valid;
  logic last_op;
  logic take;
  logic useful;

  always_comb begin
    last_op   = (cur.kind != REQ_RENDER) || (cur.idx == '1);
    req.ready = !cur_valid || (adv && last_op);
    take      = req.valid && req.ready;
    useful    = (req.req_type == REQ_PLANE_WR) || (req.req_type == REQ_BG_WR) ||
                ((req.req_type == REQ_RENDER) && (req.line < LINE_W'(PAPER_LINES)));
    op_valid  = cur_valid;
    op        = cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      cur_valid <= useful;
    end else if (adv && last_op) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur.kind     <= req_type_e'(req.req_type);
      cur.plane    <= req.plane;
      cur.bg_slot  <= req.bg_slot;
      cur.mem_addr <= req.mem_addr;
      cur.wr_data  <= req.wr_data;
      cur.column   <= req.column;
      cur.line     <= req.line;
      cur.idx      <= '0;
    end else if (adv && cur_valid && !last_op) begin
      cur.idx <= cur.idx + PIX_IDX_W'(1);
    end
  end

endmodule

FILE: rtl/pck_addr.sv
// Address stage: plane and background addresses and write qualifiers.
module pck_addr #(
  parameter int NUM_BACKGROUNDS = pck_pkg::DEF_NUM_BACKGROUNDS,
  parameter int IMG_W           = pck_pkg::DEF_IMG_W,
  parameter int IMG_H           = pck_pkg::DEF_IMG_H,
  localparam int BG_AW          = $clog2(NUM_BACKGROUNDS * IMG_W * IMG_H)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          bg_enable,
  input  logic [pck_pkg::SLOT_W-1:0]    bg_select,
  input  logic                          in_valid,
  input  pck_pkg::op_t                  in_op,
  output logic                          out_valid,
  output pck_pkg::op_t                  out_op,
  output logic [pck_pkg::PLANE_AW-1:0]  plane_addr,
  output logic [BG_AW-1:0]              bg_addr,
  output logic                          wr_ok,
  output logic                          key_ok
);
  import pck_pkg::*;

  localparam int IMG_BYTES = IMG_W * IMG_H;
  localparam int BG_X0     = IMG_W / 2 - 128;
  localparam int BG_Y0     = IMG_H / 2 - 96;

  logic [PLANE_AW-1:0] plane_addr_next;
  logic [BG_AW-1:0]    bg_addr_next;
  logic [BG_AW-1:0]    img_off;
  logic [SLOT_W-1:0]   slot;
  logic                wr_ok_next;
  logic                key_ok_next;

  always_comb begin
    if (in_op.kind == REQ_RENDER) begin
      plane_addr_next = swap_addr({in_op.line[PLANE_AW-COL_W-1:0], in_op.column});
    end else begin
      plane_addr_next = in_op.mem_addr[PLANE_AW-1:0];
    end

    if (in_op.kind == REQ_BG_WR) begin
      slot    = in_op.bg_slot;
      img_off = BG_AW'(in_op.mem_addr);
    end else begin
      slot    = bg_select;
      img_off = (BG_AW'(BG_Y0) + BG_AW'(in_op.line)) * BG_AW'(IMG_W) + BG_AW'(BG_X0) +
                BG_AW'({in_op.column, in_op.idx});
    end
    bg_addr_next = BG_AW'(slot) * BG_AW'(IMG_BYTES) + img_off;

    case (in_op.kind)
      REQ_PLANE_WR: wr_ok_next = 32'(in_op.mem_addr) < 32'(PLANE_DEPTH);
      REQ_BG_WR:    wr_ok_next = (32'(in_op.mem_addr) < 32'(IMG_BYTES)) &&
                                 (32'(in_op.bg_slot) < 32'(NUM_BACKGROUNDS));
      default:      wr_ok_next = 1'b0;
    endcase

    key_ok_next = bg_enable && (32'(bg_select) < 32'(NUM_BACKGROUNDS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_op     <= in_op;
      plane_addr <= plane_addr_next;
      bg_addr    <= bg_addr_next;
      wr_ok      <= wr_ok_next;
      key_ok     <= key_ok_next;
    end
  end

endmodule

FILE: rtl/pck_mem.sv
// Memory stage: eight plane RAMs and the background RAM, written and read here.
module pck_mem #(
  parameter int NUM_BACKGROUNDS = pck_pkg::DEF_NUM_BACKGROUNDS,
  parameter int IMG_W           = pck_pkg::DEF_IMG_W,
  parameter int IMG_H           = pck_pkg::DEF_IMG_H,
  localparam int BG_BYTES       = NUM_BACKGROUNDS * IMG_W * IMG_H,
  localparam int BG_AW          = $clog2(BG_BYTES)
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        adv,
  input  logic                                        in_valid,
  input  pck_pkg::op_t                                in_op,
  input  logic [pck_pkg::PLANE_AW-1:0]                plane_addr,
  input  logic [BG_AW-1:0]                            bg_addr,
  input  logic                                        wr_ok,
  input  logic                                        key_ok,
  output logic                                        out_valid,
  output pck_pkg::op_t                                out_op,
  output logic                                        out_key,
  output logic [pck_pkg::NUM_PLANES-1:0][pck_pkg::BYTE_W-1:0] plane_q,
  output logic [pck_pkg::BYTE_W-1:0]                  bg_q
);
  import pck_pkg::*;

  logic go;
  logic rd;

  always_comb begin
    go = adv && in_valid;
    rd = go && (in_op.kind == REQ_RENDER);
  end

  for (genvar j = 0; j < NUM_PLANES; j++) begin : g_plane
    pck_ram #(.WIDTH(BYTE_W), .DEPTH(PLANE_DEPTH)) u_plane_ram (
      .clk   (clk),
      .we    (go && wr_ok && (in_op.kind == REQ_PLANE_WR) &&
              (in_op.plane == PLANE_W'(j))),
      .waddr (plane_addr),
      .wdata (in_op.wr_data),
      .re    (rd),
      .raddr (plane_addr),
      .rdata (plane_q[j])
    );
  end

  pck_ram #(.WIDTH(BYTE_W), .DEPTH(BG_BYTES)) u_bg_ram (
    .clk   (clk),
    .we    (go && wr_ok && (in_op.kind == REQ_BG_WR)),
    .waddr (bg_addr),
    .wdata (in_op.wr_data),
    .re    (rd),
    .raddr (bg_addr),
    .rdata (bg_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_op  <= in_op;
      out_key <= key_ok;
    end
  end

endmodule

FILE: rtl/pck_compose.sv
// Output stage: transpose plane bits into a colour, apply the key, hold the pixel.
module pck_compose #(
  parameter int PAPER_X0 = pck_pkg::DEF_PAPER_X0,
  parameter int PAPER_Y0 = pck_pkg::DEF_PAPER_Y0
) (
  input  logic                                                clk,
  input  logic                                                rst,
  output logic                                                adv,
  input  logic                                                in_valid,
  input  pck_pkg::op_t                                        in_op,
  input  logic                                                in_key,
  input  logic [pck_pkg::NUM_PLANES-1:0][pck_pkg::BYTE_W-1:0] plane_q,
  input  logic [pck_pkg::BYTE_W-1:0]                          bg_q,
  pck_out_if.source                                           pix
);
  import pck_pkg::*;

  logic [BYTE_W-1:0] color;
  logic [BYTE_W-1:0] color_next;
  logic [PIX_IDX_W-1:0] bit_sel;
  logic pix_valid;

  always_comb begin
    adv     = !pix_valid || pix.ready;
    bit_sel = ~in_op.idx;
    for (int j = 0; j < NUM_PLANES; j++) begin
      color[j] = plane_q[j][bit_sel];
    end
    color_next = ((color == '0) && in_key) ? bg_q : color;
    pix.valid  = pix_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (adv) begin
      pix_valid <= in_valid && (in_op.kind == REQ_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix.pixel_x     <= POS_W'(PAPER_X0) + POS_W'({in_op.column, in_op.idx});
      pix.pixel_y     <= POS_W'(PAPER_Y0) + POS_W'(in_op.line);
      pix.pixel_color <= color_next;
      pix.last_pixel  <= (in_op.idx == '1);
    end
  end

endmodule

FILE: rtl/planar_color_key_compositor.sv
// Top level of the planar colour-key compositor: pipeline, config registers, checks.
//
// Usage:
//   req  - request items. req_type 0 stores wr_data into bitplane 'plane' at
//          mem_addr, 1 stores it into background slot bg_slot at mem_addr, 2
//          renders paper column 'column' of line 'line', 3 is a no-op.
//          Out-of-range writes and renders of lines past 191 are dropped.
//   pix  - pixel items, eight per render item in left-to-right order, the
//          eighth flagged by last_pixel. Zero plane colours are replaced by
//          the selected background pixel (centred) when bg_enable is set.
//   cfg  - cfg_we/cfg_index/cfg_data write bg_enable (0) and bg_select (1);
//          write only while no item is in flight.
// Timing: four register stages (expand, address, memory read, output); the
//   expander loads at acceptance, and pixels then pass the other stages in order.
//   While the pipeline is not stalled a write item is accepted every cycle;
//   a render item holds the front stage until all eight pixels have issued,
//   one pixel per clock while not stalled, so the next item waits for them.
// Reset: rst is synchronous; it empties the pipeline and clears the config
//   registers. Plane and background memories keep their contents and are
//   undefined until written.
// Stall: while a pixel waits with pix.ready low the pipeline holds; only an empty expander still loads.
module planar_color_key_compositor #(
  parameter int NUM_BACKGROUNDS = pck_pkg::DEF_NUM_BACKGROUNDS,
  parameter int IMG_W           = pck_pkg::DEF_IMG_W,
  parameter int IMG_H           = pck_pkg::DEF_IMG_H,
  parameter int PAPER_X0        = pck_pkg::DEF_PAPER_X0,
  parameter int PAPER_Y0        = pck_pkg::DEF_PAPER_Y0
) (
  input  logic                          clk,
  input  logic                          rst,
  pck_in_if.sink                        req,
  pck_out_if.source                     pix,
  input  logic                          cfg_we,
  input  logic [pck_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pck_pkg::CFG_DAT_W-1:0] cfg_data
);
  import pck_pkg::*;

  localparam int BG_AW = $clog2(NUM_BACKGROUNDS * IMG_W * IMG_H);

  // Configuration registers.
  logic              bg_enable;
  logic [SLOT_W-1:0] bg_select;

  // Global advance: the stages move when the output register can take data; an empty expander may still load.
  logic adv;

  // Stage 0: expander output.
  logic s0_valid;
  op_t  s0_op;

  // Stage 1: addresses.
  logic                s1_valid;
  op_t                 s1_op;
  logic [PLANE_AW-1:0] s1_plane_addr;
  logic [BG_AW-1:0]    s1_bg_addr;
  logic                s1_wr_ok;
  logic                s1_key_ok;

  // Stage 2: memory read data.
  logic                                 s2_valid;
  op_t                                  s2_op;
  logic                                 s2_key;
  logic [NUM_PLANES-1:0][BYTE_W-1:0]    s2_plane_q;
  logic [BYTE_W-1:0]                    s2_bg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_enable <= 1'b0;
      bg_select <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_BG_ENABLE: bg_enable <= cfg_data[0];
        CFG_BG_SELECT: bg_select <= cfg_data[SLOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Split render items into per-pixel operations.
  pck_expand u_expand (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .req      (req),
    .op_valid (s0_valid),
    .op       (s0_op)
  );

  // Work out memory addresses and whether writes land.
  pck_addr #(
    .NUM_BACKGROUNDS (NUM_BACKGROUNDS),
    .IMG_W           (IMG_W),
    .IMG_H           (IMG_H)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .bg_enable  (bg_enable),
    .bg_select  (bg_select),
    .in_valid   (s0_valid),
    .in_op      (s0_op),
    .out_valid  (s1_valid),
    .out_op     (s1_op),
    .plane_addr (s1_plane_addr),
    .bg_addr    (s1_bg_addr),
    .wr_ok      (s1_wr_ok),
    .key_ok     (s1_key_ok)
  );

  // Perform writes, read planes and background for pixels.
  pck_mem #(
    .NUM_BACKGROUNDS (NUM_BACKGROUNDS),
    .IMG_W           (IMG_W),
    .IMG_H           (IMG_H)
  ) u_mem (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (s1_valid),
    .in_op      (s1_op),
    .plane_addr (s1_plane_addr),
    .bg_addr    (s1_bg_addr),
    .wr_ok      (s1_wr_ok),
    .key_ok     (s1_key_ok),
    .out_valid  (s2_valid),
    .out_op     (s2_op),
    .out_key    (s2_key),
    .plane_q    (s2_plane_q),
    .bg_q       (s2_bg_q)
  );

  // Build the colour, apply the key and present the pixel.
  pck_compose #(
    .PAPER_X0 (PAPER_X0),
    .PAPER_Y0 (PAPER_Y0)
  ) u_compose (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s2_valid),
    .in_op    (s2_op),
    .in_key   (s2_key),
    .plane_q  (s2_plane_q),
    .bg_q     (s2_bg_q),
    .pix      (pix)
  );

`ifndef SYNTHESIS
  localparam logic [2:0] LAST_X_LSB = 3'(PAPER_X0 + 7);

  // The flagged pixel is always the rightmost of its column.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.last_pixel) |-> (pix.pixel_x[2:0] == LAST_X_LSB))
    else $error("last pixel not at column end");

  // An accepted render of a visible line must occupy the front stage.
  a_render_taken: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.req_type == REQ_RENDER) &&
     (req.line < LINE_W'(PAPER_LINES))) |=> (s0_valid && (s0_op.idx == '0)))
    else $error("render item not loaded into expander");

  // The expander keeps stepping through all eight pixels of a render item.
  a_pixel_step: assert property (@(posedge clk) disable iff (rst)
    (s0_valid && (s0_op.kind == REQ_RENDER) && (s0_op.idx != '1) && adv) |=>
    (s0_valid && (s0_op.idx == $past(s0_op.idx) + PIX_IDX_W'(1))))
    else $error("expander skipped or lost a pixel");
`endif

endmodule
